### design/cds3d_pkg.sv
// ----------------------------------------------------------------------------
// cds3d_pkg: shared types and constants for the 3D spring smoother
// Payload structs, register indexes, command codes, arithmetic widths and the
// coordinate saturation function.
// ----------------------------------------------------------------------------
package cds3d_pkg;

	// Coordinate format
	localparam int COORD_W = 32;
	localparam int AXES    = 3;
	localparam int AXIS_W  = 2;
	localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

	// Command codes
	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_GOAL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_JUMP     = 2'd2;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_DT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSTEPS = 2'd3;

	localparam int GAIN_POS_W = 32;
	localparam int GAIN_VEL_W = 17;
	localparam int SUB_DT_W   = 25;
	localparam int SUBSTEPS_W = 16;

	localparam logic [GAIN_POS_W-1:0] GAIN_POS_RST = 32'd65536;
	localparam logic [GAIN_VEL_W-1:0] GAIN_VEL_RST = 17'd32768;
	localparam logic [SUB_DT_W-1:0]   SUB_DT_RST   = 25'd16777;
	localparam logic [SUBSTEPS_W-1:0] SUBSTEPS_RST = 16'd1;

	// Multiplier: signed operand times unsigned coefficient, one digit a cycle
	localparam int GAIN_SHIFT  = 16;
	localparam int DT_SHIFT    = 24;
	localparam int MUL_DIGIT_W = 32;
	localparam int MUL_B_W     = GAIN_POS_W;
	localparam int OP_W        = COORD_W + 1;
	localparam int MUL_DIGITS  = (OP_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
	localparam int MAG_W       = MUL_DIGITS * MUL_DIGIT_W;
	localparam int PROD_W      = MAG_W + MUL_B_W;
	localparam int RND_W       = PROD_W + 1 - GAIN_SHIFT;
	localparam int RES_W       = RND_W + 1;
	localparam int SUM_W       = RES_W + 2;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
		logic signed [COORD_W-1:0] vel_z;
	} out_item_t;

	// Which product the shared multiplier forms
	typedef enum logic [1:0] {
		MSEL_ERR  = 2'd0,   // (goal - pos) * gain_pos
		MSEL_DAMP = 2'd1,   // vel * gain_vel
		MSEL_STEP = 2'd2    // new vel * sub_dt
	} mul_sel_t;

	typedef struct packed {
		logic              mul_start;
		mul_sel_t          mul_sel;
		logic              take_t1;
		logic              upd_vel;
		logic              upd_pos;
		logic              load_goal;
		logic              jump;
		logic              load_out;
		logic [AXIS_W-1:0] axis;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mul_done;
	} dp_status_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

### design/cds3d_mul.sv
// ----------------------------------------------------------------------------
// cds3d_mul: digit-serial rounding multiplier
// Forms round(a * b / 2^sh) with ties away from zero, sh being 16 or 24.
// One 32x32 partial product per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module cds3d_mul import cds3d_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [OP_W-1:0]  a,
	input  logic [MUL_B_W-1:0]      b,
	input  logic                    sh_dt,
	output logic                    done,
	output logic signed [RES_W-1:0] res
);

	localparam int CNT_W = $clog2(MUL_DIGITS + 1);
	localparam logic [PROD_W:0] RND_GAIN =
		{{(PROD_W+1-GAIN_SHIFT){1'b0}}, 1'b1, {(GAIN_SHIFT-1){1'b0}}};
	localparam logic [PROD_W:0] RND_DT =
		{{(PROD_W+1-DT_SHIFT){1'b0}}, 1'b1, {(DT_SHIFT-1){1'b0}}};

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ACC  = 3'b010,
		PH_RND  = 3'b100
	} mul_phase_t;

	mul_phase_t                     phase_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [MAG_W-1:0]               mag_q;
	logic [MUL_B_W-1:0]             b_q;
	logic                           neg_q;
	logic                           sh_dt_q;
	logic [PROD_W-1:0]              acc_q;
	logic                           done_q;
	logic signed [RES_W-1:0]        res_q;

	logic [OP_W-1:0]                a_mag;
	logic [MUL_DIGIT_W+MUL_B_W-1:0] pp;
	logic [PROD_W:0]                rsum;
	logic [PROD_W:0]                shr;
	logic [RND_W-1:0]               rmag;

	assign a_mag = a[OP_W-1] ? $unsigned(-a) : $unsigned(a);
	assign pp    = mag_q[MAG_W-1 -: MUL_DIGIT_W] * b_q;
	assign rsum  = {1'b0, acc_q} + (sh_dt_q ? RND_DT : RND_GAIN);
	assign shr   = sh_dt_q ? (rsum >> DT_SHIFT) : (rsum >> GAIN_SHIFT);
	assign rmag  = shr[RND_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						cnt_q   <= CNT_W'(MUL_DIGITS);
						phase_q <= PH_ACC;
					end
				end
				PH_ACC: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						phase_q <= PH_RND;
					end
				end
				PH_RND: begin
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Operand and product registers
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			mag_q   <= MAG_W'(a_mag);
			neg_q   <= a[OP_W-1];
			b_q     <= b;
			sh_dt_q <= sh_dt;
			acc_q   <= '0;
		end else if (phase_q == PH_ACC) begin
			mag_q <= mag_q << MUL_DIGIT_W;
			acc_q <= (acc_q << MUL_DIGIT_W) + PROD_W'(pp);
		end
		if (phase_q == PH_RND) begin
			res_q <= neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> phase_q == PH_IDLE)
		else $error("multiplier started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiplier done held longer than one cycle");
`endif

endmodule

### design/cds3d_dp.sv
// ----------------------------------------------------------------------------
// cds3d_dp: spring datapath
// Holds position, velocity and goal per axis, the coefficient registers, the
// shared multiplier and the output register.
// ----------------------------------------------------------------------------
module cds3d_dp import cds3d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctrl_cmd_t             ctl,
	output dp_status_t            sts,
	output out_item_t             out_data
);

	logic signed [COORD_W-1:0] pos_q  [AXES];
	logic signed [COORD_W-1:0] vel_q  [AXES];
	logic signed [COORD_W-1:0] goal_q [AXES];
	logic [GAIN_POS_W-1:0]     gain_pos_q;
	logic [GAIN_VEL_W-1:0]     gain_vel_q;
	logic [SUB_DT_W-1:0]       sub_dt_q;
	logic signed [SUM_W-1:0]   acc_q;
	out_item_t                 out_q;

	logic signed [COORD_W-1:0] coord [AXES];
	logic signed [COORD_W-1:0] pos_a;
	logic signed [COORD_W-1:0] vel_a;
	logic signed [COORD_W-1:0] goal_a;
	logic signed [OP_W-1:0]    op_a;
	logic [MUL_B_W-1:0]        op_b;
	logic                      op_sh_dt;
	logic                      mul_done;
	logic signed [RES_W-1:0]   mul_res;

	assign coord[0] = in_data.coord_x;
	assign coord[1] = in_data.coord_y;
	assign coord[2] = in_data.coord_z;

	assign pos_a  = pos_q[ctl.axis];
	assign vel_a  = vel_q[ctl.axis];
	assign goal_a = goal_q[ctl.axis];

	always_comb begin
		op_a     = OP_W'(goal_a) - OP_W'(pos_a);
		op_b     = gain_pos_q;
		op_sh_dt = 1'b0;
		case (ctl.mul_sel)
			MSEL_ERR: begin
				op_a     = OP_W'(goal_a) - OP_W'(pos_a);
				op_b     = gain_pos_q;
				op_sh_dt = 1'b0;
			end
			MSEL_DAMP: begin
				op_a     = OP_W'(vel_a);
				op_b     = MUL_B_W'(gain_vel_q);
				op_sh_dt = 1'b0;
			end
			MSEL_STEP: begin
				op_a     = OP_W'(vel_a);
				op_b     = MUL_B_W'(sub_dt_q);
				op_sh_dt = 1'b1;
			end
			default: begin
				op_a     = OP_W'(goal_a) - OP_W'(pos_a);
				op_b     = gain_pos_q;
				op_sh_dt = 1'b0;
			end
		endcase
	end

	cds3d_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.a      (op_a),
		.b      (op_b),
		.sh_dt  (op_sh_dt),
		.done   (mul_done),
		.res    (mul_res)
	);

	assign sts.mul_done = mul_done;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_pos_q <= GAIN_POS_RST;
			gain_vel_q <= GAIN_VEL_RST;
			sub_dt_q   <= SUB_DT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_POS: gain_pos_q <= cfg_data[GAIN_POS_W-1:0];
				REG_GAIN_VEL: gain_vel_q <= cfg_data[GAIN_VEL_W-1:0];
				REG_SUB_DT:   sub_dt_q   <= cfg_data[SUB_DT_W-1:0];
				default: ;
			endcase
		end
	end

	// Axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				pos_q[i]  <= '0;
				vel_q[i]  <= '0;
				goal_q[i] <= '0;
			end
		end else begin
			if (ctl.load_goal) begin
				for (int i = 0; i < AXES; i++) begin
					goal_q[i] <= coord[i];
					if (ctl.jump) begin
						pos_q[i] <= coord[i];
						vel_q[i] <= '0;
					end
				end
			end
			if (ctl.upd_vel) begin
				vel_q[ctl.axis] <= sat_coord(acc_q - SUM_W'(mul_res));
			end
			if (ctl.upd_pos) begin
				pos_q[ctl.axis] <= sat_coord(SUM_W'(pos_a) + SUM_W'(mul_res));
			end
		end
	end

	// Partial velocity sum and output register
	always_ff @(posedge clk) begin
		if (ctl.take_t1) begin
			acc_q <= SUM_W'(vel_a) + SUM_W'(mul_res);
		end
		if (ctl.load_out) begin
			out_q.pos_x <= pos_q[0];
			out_q.pos_y <= pos_q[1];
			out_q.pos_z <= pos_q[2];
			out_q.vel_x <= vel_q[0];
			out_q.vel_y <= vel_q[1];
			out_q.vel_z <= vel_q[2];
		end
	end

	assign out_data = out_q;

endmodule

### design/cds3d_ctrl.sv
// ----------------------------------------------------------------------------
// cds3d_ctrl: spring sequencer
// Accepts commands, walks substeps and axes through the three products of
// each Euler substep and owns the result valid flag.
// ----------------------------------------------------------------------------
module cds3d_ctrl import cds3d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      in_cmd,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_status_t            sts,
	output ctrl_cmd_t             ctl
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_M1   = 8'b0000_0010,
		S_W1   = 8'b0000_0100,
		S_M2   = 8'b0000_1000,
		S_W2   = 8'b0001_0000,
		S_M3   = 8'b0010_0000,
		S_W3   = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} ctrl_state_t;

	ctrl_state_t           state_q, state_d;
	logic [AXIS_W-1:0]     axis_q, axis_d;
	logic [SUBSTEPS_W-1:0] left_q, left_d;
	logic [SUBSTEPS_W-1:0] substeps_q;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		left_d  = left_q;
		ctl         = '0;
		ctl.mul_sel = MSEL_ERR;
		ctl.axis    = axis_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_TICK: begin
							axis_d = '0;
							left_d = substeps_q;
							state_d = (substeps_q == '0) ? S_DONE : S_M1;
						end
						CMD_SET_GOAL: ctl.load_goal = 1'b1;
						CMD_JUMP: begin
							ctl.load_goal = 1'b1;
							ctl.jump      = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_M1: begin
				ctl.mul_start = 1'b1;
				ctl.mul_sel   = MSEL_ERR;
				state_d       = S_W1;
			end
			S_W1: begin
				if (sts.mul_done) begin
					ctl.take_t1 = 1'b1;
					state_d     = S_M2;
				end
			end
			S_M2: begin
				ctl.mul_start = 1'b1;
				ctl.mul_sel   = MSEL_DAMP;
				state_d       = S_W2;
			end
			S_W2: begin
				if (sts.mul_done) begin
					ctl.upd_vel = 1'b1;
					state_d     = S_M3;
				end
			end
			S_M3: begin
				ctl.mul_start = 1'b1;
				ctl.mul_sel   = MSEL_STEP;
				state_d       = S_W3;
			end
			S_W3: begin
				ctl.mul_sel = MSEL_STEP;
				if (sts.mul_done) begin
					ctl.upd_pos = 1'b1;
					// advance axis, then substep
					if (axis_q == AXIS_LAST) begin
						axis_d = '0;
						if (left_q == SUBSTEPS_W'(1)) begin
							state_d = S_DONE;
						end else begin
							left_d  = left_q - SUBSTEPS_W'(1);
							state_d = S_M1;
						end
					end else begin
						axis_d  = axis_q + AXIS_W'(1);
						state_d = S_M1;
					end
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			left_q      <= '0;
			substeps_q  <= SUBSTEPS_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			left_q  <= left_d;
			if (cfg_we && cfg_index == REG_SUBSTEPS) begin
				substeps_q <= cfg_data[SUBSTEPS_W-1:0];
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q <= AXIS_LAST)
		else $error("axis counter out of range");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == S_W1 || state_q == S_W2 || state_q == S_W3))
		else $error("product finished outside a wait state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while still stalled");
`endif

endmodule

### design/critically_damped_spring_3d.sv
// ----------------------------------------------------------------------------
// critically_damped_spring_3d: three-axis critically damped spring smoother
// Input channel carries commands (tick, set goal, jump) with coordinates;
// output channel carries position and velocity after each tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data: one command per transaction. Set goal and jump
//   produce no result; code 3 is dropped.
//   out_valid/out_stall/out_data: one result per tick command.
//   cfg_we/cfg_index/cfg_data: coefficient writes, only while idle.
// Sequence: a tick runs each Euler substep on the three axes in
//   turn, three products per axis through one shared multiplier that takes
//   one 32x32 digit per cycle. The next command is accepted in the cycle
//   after the result is written to the output register.
// Stall: a stalled result holds in the output register while the next
//   command is accepted; a tick that finishes behind it waits.
// Reset: all positions, velocities and goals clear to zero, coefficients
//   return to their defaults, no result is pending.
// ----------------------------------------------------------------------------
module critically_damped_spring_3d import cds3d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	cds3d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_cmd    (in_data.cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.ctl       (ctl)
	);

	cds3d_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
